### hw/rtl/rtc_tz_pkg.sv
// rtc_tz_pkg: types, constants and calendar helpers for the time-zone rtc
// used by rtc_calendar_time_zone; no dependencies

package rtc_tz_pkg;

  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned ZONE_W   = 5;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned UPTIME_W = 32;

  localparam logic [HOUR_W-1:0]   HOURS_PER_DAY = 5'd24;
  localparam logic [MIN_W:0]      MIN_PER_HOUR  = 7'd60;
  localparam logic [MONTH_W-1:0]  MONTH_DEC     = 4'd12;
  localparam logic [MONTH_W-1:0]  MONTH_JAN     = 4'd1;
  localparam logic [MONTH_W-1:0]  MONTH_FEB     = 4'd2;
  localparam logic [DAY_W-1:0]    FEB_LEAP_DAYS = 5'd29;
  localparam logic [YEAR_W-1:0]   YEAR_MAX      = 14'd9999;
  localparam logic [WDAY_W-1:0]   WDAY_MON      = 3'd1;
  localparam logic [WDAY_W-1:0]   WDAY_SUN      = 3'd7;
  localparam logic [UPTIME_W-1:0] MS_PER_TICK   = 32'd10;

  // floor(y / 100) = (y * 5243) >> 19 for every 14-bit year
  localparam logic [12:0]         CENT_RECIP    = 13'd5243;
  localparam int unsigned         CENT_SHIFT    = 19;
  localparam logic [YEAR_W-1:0]   CENT_YEARS    = 14'd100;

  localparam logic [CFG_W-1:0]    TPS_RESET     = 8'd100;
  localparam logic [CFG_W-1:0]    LED_RESET     = 8'd20;
  localparam logic [ZONE_W-1:0]   ZONE_A_RESET  = 5'sd2;
  localparam logic [ZONE_W-1:0]   ZONE_B_RESET  = -5'sd4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_TOGGLE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_TPS    = 2'd0,
    CFG_LED    = 2'd1,
    CFG_ZONE_A = 2'd2,
    CFG_ZONE_B = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [WDAY_W-1:0]  weekday;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
    logic [MIN_W-1:0]    seconds;
    date_t               date;
    logic                zone_is_b;
    logic                led_on;
    logic                second_tick;
    logic [UPTIME_W-1:0] uptime_ms;
  } res_t;

  // month lengths, unused month codes count as 31
  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  function automatic logic is_leap(logic [YEAR_W-1:0] y);
    logic [26:0]        prod;
    logic [7:0]         cent;
    logic [YEAR_W-1:0]  rem;
    prod = 27'(y) * 27'(CENT_RECIP);
    cent = prod[CENT_SHIFT +: 8];
    rem  = y - YEAR_W'(14'(cent) * CENT_YEARS);
    return ((y[1:0] == 2'b00) && (rem != '0)) || ((rem == '0) && (cent[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    len = MONTH_LEN[m];
    if ((m == MONTH_FEB) && leap) len = FEB_LEAP_DAYS;
    return len;
  endfunction

  function automatic date_t day_back(date_t d, logic leap);
    date_t r;
    r = d;
    if (d.day <= DAY_W'(1)) begin
      if (d.month <= MONTH_JAN) begin
        r.month = MONTH_DEC;
        if (d.year != '0) r.year = d.year - YEAR_W'(1);
      end else begin
        r.month = d.month - MONTH_W'(1);
      end
      r.day = month_days(r.month, leap);
    end else begin
      r.day = d.day - DAY_W'(1);
    end
    r.weekday = (d.weekday <= WDAY_MON) ? WDAY_SUN : d.weekday - WDAY_W'(1);
    return r;
  endfunction

  function automatic date_t day_forward(date_t d, logic leap);
    date_t           r;
    logic [DAY_W:0]  nd;
    r  = d;
    nd = {1'b0, d.day} + (DAY_W+1)'(1);
    if (nd > {1'b0, month_days(d.month, leap)}) begin
      r.day = DAY_W'(1);
      if (d.month >= MONTH_DEC) begin
        r.month = MONTH_JAN;
        if (d.year < YEAR_MAX) r.year = d.year + YEAR_W'(1);
      end else begin
        r.month = d.month + MONTH_W'(1);
      end
    end else begin
      r.day = nd[DAY_W-1:0];
    end
    r.weekday = (d.weekday >= WDAY_SUN) ? WDAY_MON : d.weekday + WDAY_W'(1);
    return r;
  endfunction

endpackage

### hw/rtl/rtc_calendar_time_zone.sv
// rtc_calendar_time_zone: real-time clock with calendar and two time zones
// depends on rtc_tz_pkg for types, constants and calendar helpers
//
// in_* channel takes one item per transfer: a 10 ms tick, a set of time and
// date given in zone in_set_zone, or a zone toggle. every item gives exactly
// one result on the out_* channel: the time, date, zone, led level, a second
// flag and the uptime after that item.
// each item updates the clock registers at its transfer; its result goes to
// the output register, or to the skid entry while an unread result waits.
// one item per cycle is sustained while in_stall is low, and in_stall rises
// only when both the output register and the skid entry hold results.
// the cfg_* port writes a register at any edge with cfg_we high outside
// reset; it is meant to be written while no item is in flight.
// reset (rst_n low at a clock edge) clears time, date, uptime and both
// result entries, selects zone A at offset +2 and loads the register
// defaults (100 ticks a second, led off at 20, zone A +2, zone B -4).

module rtc_calendar_time_zone (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_operation,
  input  logic [rtc_tz_pkg::HOUR_W-1:0]      in_set_hours,
  input  logic [rtc_tz_pkg::MIN_W-1:0]       in_set_minutes,
  input  logic [rtc_tz_pkg::MIN_W-1:0]       in_set_seconds,
  input  logic [rtc_tz_pkg::DAY_W-1:0]       in_set_day,
  input  logic [rtc_tz_pkg::MONTH_W-1:0]     in_set_month,
  input  logic [rtc_tz_pkg::YEAR_W-1:0]      in_set_year,
  input  logic [rtc_tz_pkg::WDAY_W-1:0]      in_set_weekday,
  input  logic signed [rtc_tz_pkg::ZONE_W-1:0] in_set_zone,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rtc_tz_pkg::HOUR_W-1:0]      out_hours,
  output logic [rtc_tz_pkg::MIN_W-1:0]       out_minutes,
  output logic [rtc_tz_pkg::MIN_W-1:0]       out_seconds,
  output logic [rtc_tz_pkg::DAY_W-1:0]       out_day,
  output logic [rtc_tz_pkg::MONTH_W-1:0]     out_month,
  output logic [rtc_tz_pkg::YEAR_W-1:0]      out_year,
  output logic [rtc_tz_pkg::WDAY_W-1:0]      out_weekday,
  output logic                               out_zone_is_b,
  output logic                               out_led_on,
  output logic                               out_second_tick,
  output logic [rtc_tz_pkg::UPTIME_W-1:0]    out_uptime_ms,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [rtc_tz_pkg::CFG_W-1:0]       cfg_wdata
);

  // configuration
  logic [rtc_tz_pkg::CFG_W-1:0]  cfg_tps_r;
  logic [rtc_tz_pkg::CFG_W-1:0]  cfg_led_r;
  logic [rtc_tz_pkg::ZONE_W-1:0] cfg_zone_a_r;
  logic [rtc_tz_pkg::ZONE_W-1:0] cfg_zone_b_r;

  // clock state
  logic [rtc_tz_pkg::CFG_W-1:0]    tick_r,   tick_nxt;
  logic [rtc_tz_pkg::UPTIME_W-1:0] uptime_r, uptime_nxt;
  logic [rtc_tz_pkg::HOUR_W-1:0]   hour_r,   hour_nxt;
  logic [rtc_tz_pkg::MIN_W-1:0]    min_r,    min_nxt;
  logic [rtc_tz_pkg::MIN_W-1:0]    sec_r,    sec_nxt;
  rtc_tz_pkg::date_t               date_r,   date_nxt;
  logic [rtc_tz_pkg::ZONE_W-1:0]   zone_r,   zone_nxt;
  logic                            zone_b_r, zone_b_nxt;
  logic                            led_r,    led_nxt;

  // result buffer
  rtc_tz_pkg::res_t out_r, out_nxt, skid_r, skid_nxt, res;
  logic             out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic                                 accept, drain, sec_done;
  rtc_tz_pkg::op_t                      op;
  logic [rtc_tz_pkg::CFG_W-1:0]         tick_inc;
  logic [rtc_tz_pkg::MIN_W:0]           sec_inc, min_inc;
  logic [rtc_tz_pkg::HOUR_W-1:0]        hour_inc;

  // zone shift path
  logic                                 set_sel, leap;
  rtc_tz_pkg::date_t                    base_date, step1, step2, shift_date;
  logic [rtc_tz_pkg::HOUR_W-1:0]        base_hour, shift_hour;
  logic [rtc_tz_pkg::ZONE_W-1:0]        zone_from, zone_to;
  logic signed [7:0]                    hour_sum, hour_fix;
  logic                                 go_back, two_steps, one_step;

  assign accept   = in_valid && !in_stall;
  assign drain    = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;
  assign op       = rtc_tz_pkg::op_t'(in_operation);

  assign tick_inc = tick_r + rtc_tz_pkg::CFG_W'(1);
  assign sec_inc  = {1'b0, sec_r} + (rtc_tz_pkg::MIN_W+1)'(1);
  assign min_inc  = {1'b0, min_r} + (rtc_tz_pkg::MIN_W+1)'(1);
  assign hour_inc = hour_r + rtc_tz_pkg::HOUR_W'(1);

  always_comb begin
    set_sel = (op == rtc_tz_pkg::OP_SET);
    if (set_sel) begin
      base_date.day     = in_set_day;
      base_date.month   = in_set_month;
      base_date.year    = (in_set_year > rtc_tz_pkg::YEAR_MAX) ? rtc_tz_pkg::YEAR_MAX
                                                                : in_set_year;
      base_date.weekday = in_set_weekday;
      base_hour         = in_set_hours;
      zone_from         = in_set_zone;
      zone_to           = zone_r;
    end else begin
      base_date         = date_r;
      base_hour         = hour_r;
      zone_from         = zone_r;
      zone_to           = zone_b_r ? cfg_zone_a_r : cfg_zone_b_r;
    end
  end

  always_comb begin
    hour_sum  = $signed({3'b000, base_hour})
              + $signed({{3{zone_to[rtc_tz_pkg::ZONE_W-1]}}, zone_to})
              - $signed({{3{zone_from[rtc_tz_pkg::ZONE_W-1]}}, zone_from});
    go_back   = hour_sum < 8'sd0;
    two_steps = go_back ? (hour_sum < -8'sd24) : (hour_sum >= 8'sd48);
    one_step  = go_back || (hour_sum >= 8'sd24);
    if (go_back) begin
      hour_fix = two_steps ? hour_sum + 8'sd48 : hour_sum + 8'sd24;
    end else if (two_steps) begin
      hour_fix = hour_sum - 8'sd48;
    end else if (one_step) begin
      hour_fix = hour_sum - 8'sd24;
    end else begin
      hour_fix = hour_sum;
    end
    shift_hour = hour_fix[rtc_tz_pkg::HOUR_W-1:0];
    // year changes at most once, so the base year's leap flag covers both steps
    leap  = rtc_tz_pkg::is_leap(base_date.year);
    step1 = go_back ? rtc_tz_pkg::day_back(base_date, leap)
                    : rtc_tz_pkg::day_forward(base_date, leap);
    step2 = go_back ? rtc_tz_pkg::day_back(step1, leap)
                    : rtc_tz_pkg::day_forward(step1, leap);
    shift_date = two_steps ? step2 : (one_step ? step1 : base_date);
  end

  always_comb begin
    tick_nxt   = tick_r;
    uptime_nxt = uptime_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    date_nxt   = date_r;
    zone_nxt   = zone_r;
    zone_b_nxt = zone_b_r;
    led_nxt    = led_r;
    sec_done   = 1'b0;
    if (accept) begin
      unique case (op)
        rtc_tz_pkg::OP_TICK: begin
          uptime_nxt = uptime_r + rtc_tz_pkg::MS_PER_TICK;
          tick_nxt   = tick_inc;
          if (tick_inc >= cfg_tps_r) begin
            sec_done = 1'b1;
            tick_nxt = '0;
            led_nxt  = 1'b1;
            sec_nxt  = sec_inc[rtc_tz_pkg::MIN_W-1:0];
            if (sec_inc >= rtc_tz_pkg::MIN_PER_HOUR) begin
              sec_nxt = '0;
              min_nxt = min_inc[rtc_tz_pkg::MIN_W-1:0];
              if (min_inc >= rtc_tz_pkg::MIN_PER_HOUR) begin
                min_nxt  = '0;
                hour_nxt = (hour_inc >= rtc_tz_pkg::HOURS_PER_DAY) ? '0 : hour_inc;
              end
            end
          end else if (tick_inc == cfg_led_r) begin
            led_nxt = 1'b0;
          end
        end
        rtc_tz_pkg::OP_SET: begin
          tick_nxt = '0;
          min_nxt  = in_set_minutes;
          sec_nxt  = in_set_seconds;
          hour_nxt = shift_hour;
          date_nxt = shift_date;
          zone_nxt = zone_to;
        end
        rtc_tz_pkg::OP_TOGGLE: begin
          zone_b_nxt = !zone_b_r;
          hour_nxt   = shift_hour;
          date_nxt   = shift_date;
          zone_nxt   = zone_to;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.hours       = hour_nxt;
    res.minutes     = min_nxt;
    res.seconds     = sec_nxt;
    res.date        = date_nxt;
    res.zone_is_b   = zone_b_nxt;
    res.led_on      = led_nxt;
    res.second_tick = sec_done;
    res.uptime_ms   = uptime_nxt;
  end

  // output register with one skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (drain) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || drain) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (drain) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      cfg_tps_r    <= rtc_tz_pkg::TPS_RESET;
      cfg_led_r    <= rtc_tz_pkg::LED_RESET;
      cfg_zone_a_r <= rtc_tz_pkg::ZONE_A_RESET;
      cfg_zone_b_r <= rtc_tz_pkg::ZONE_B_RESET;
      tick_r       <= '0;
      uptime_r     <= '0;
      hour_r       <= '0;
      min_r        <= '0;
      sec_r        <= '0;
      date_r       <= '0;
      zone_r       <= rtc_tz_pkg::ZONE_A_RESET;
      zone_b_r     <= 1'b0;
      led_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      tick_r       <= tick_nxt;
      uptime_r     <= uptime_nxt;
      hour_r       <= hour_nxt;
      min_r        <= min_nxt;
      sec_r        <= sec_nxt;
      date_r       <= date_nxt;
      zone_r       <= zone_nxt;
      zone_b_r     <= zone_b_nxt;
      led_r        <= led_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_we) begin
        unique case (rtc_tz_pkg::cfg_idx_t'(cfg_index))
          rtc_tz_pkg::CFG_TPS:    cfg_tps_r    <= cfg_wdata;
          rtc_tz_pkg::CFG_LED:    cfg_led_r    <= cfg_wdata;
          rtc_tz_pkg::CFG_ZONE_A: cfg_zone_a_r <= cfg_wdata[rtc_tz_pkg::ZONE_W-1:0];
          rtc_tz_pkg::CFG_ZONE_B: cfg_zone_b_r <= cfg_wdata[rtc_tz_pkg::ZONE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hours       = out_r.hours;
  assign out_minutes     = out_r.minutes;
  assign out_seconds     = out_r.seconds;
  assign out_day         = out_r.date.day;
  assign out_month       = out_r.date.month;
  assign out_year        = out_r.date.year;
  assign out_weekday     = out_r.date.weekday;
  assign out_zone_is_b   = out_r.zone_is_b;
  assign out_led_on      = out_r.led_on;
  assign out_second_tick = out_r.second_tick;
  assign out_uptime_ms   = out_r.uptime_ms;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    hour_r < rtc_tz_pkg::HOURS_PER_DAY)
    else $error("hour register out of range");

  a_second_clears_prescaler: assert property (@(posedge clk) disable iff (!rst_n)
    sec_done |=> (tick_r == '0) && led_r)
    else $error("completed second did not clear prescaler and light led");

  a_toggle_flips_zone: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == rtc_tz_pkg::OP_TOGGLE)) |=> (zone_b_r != $past(zone_b_r)))
    else $error("zone toggle did not switch zone");

  a_result_per_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("transfer produced no result");
`endif

endmodule
